>>> rtl/command_frame_deframer_router_top_defines.svh
// Assertion macros for the command frame deframer and router.
// Used by command_frame_deframer_router_top; expects clock and reset in scope.
`ifndef COMMAND_FRAME_DEFRAMER_ROUTER_TOP_DEFINES_SVH
`define COMMAND_FRAME_DEFRAMER_ROUTER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CFD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cfd assertion failed");

// Next-cycle implication, checked outside reset.
`define CFD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cfd assertion failed");

`endif

>>> rtl/cfd_pkg.sv
// Shared types and constants for the command frame deframer and router.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cfd_pkg;

   localparam int BURST_BYTES_DEFAULT = 256;

   localparam int CFG_W     = 8;
   localparam int CFG_COUNT = 5;
   localparam int CSR_IDX_W = 3;

   // Entry 0 sits in the low byte.
   localparam logic [CFG_COUNT-1:0][CFG_W-1:0] CFG_RESET =
      {8'd16, 8'd16, 8'd16, 8'd16, 8'd12};

   localparam logic [7:0] START_BYTE = 8'hA5;

   localparam logic [15:0] CMD_MOTION   = 16'h0501;
   localparam logic [15:0] CMD_ACTION   = 16'h0502;
   localparam logic [15:0] CMD_LIST     = 16'h0506;
   localparam logic [15:0] CMD_DECISION = 16'h0301;
   localparam logic [15:0] CMD_CUSTOM   = 16'h0308;

   localparam logic [2:0] CH_MOTION   = 3'd0;
   localparam logic [2:0] CH_ACTION   = 3'd1;
   localparam logic [2:0] CH_LIST     = 3'd2;
   localparam logic [2:0] CH_DECISION = 3'd3;
   localparam logic [2:0] CH_CUSTOM   = 3'd4;
   localparam logic [2:0] CH_UNKNOWN  = 3'd5;

   localparam logic [1:0] NOTIFY_NONE     = 2'd0;
   localparam logic [1:0] NOTIFY_CUSTOM   = 2'd1;
   localparam logic [1:0] NOTIFY_DECISION = 2'd2;

   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_DATA  = 1'b1;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       burst_end;
   } req_payload_type;

   typedef struct packed {
      logic       kind;
      logic [2:0] channel;
      logic [7:0] offset;
      logic [7:0] data_byte;
      logic [1:0] notify_code;
      logic       last_byte;
      logic [4:0] alive_mask;
   } rsp_payload_type;

   // Parser result handed to the output queue.
   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } cfd_result_type;

endpackage

>>> rtl/cfd_parse.sv
// Frame parser: phase register, length/command capture, channel sizes, alive bits.
// Depends on cfd_pkg; produces at most one result per accepted beat.
`timescale 1ns / 1ps

module cfd_parse import cfd_pkg::*; #(
   parameter int BurstBytes = BURST_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  req_payload_type      req_payload,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output cfd_result_type       result
);

   localparam int PosW = $clog2(BurstBytes + 1);

   typedef enum logic [3:0] {
      PH_START,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_SEQ,
      PH_HCRC,
      PH_CMD_LO,
      PH_CMD_HI,
      PH_PAYLOAD,
      PH_CRC_LO,
      PH_CRC_HI,
      PH_HALT
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [15:0]      frame_length_ff, frame_length_in;
   logic [15:0]      command_word_ff, command_word_in;
   logic [15:0]      byte_counter_ff, byte_counter_in;
   logic [2:0]       active_channel_ff, active_channel_in;
   logic [4:0]       alive_ff, alive_in;
   logic [PosW-1:0]  burst_pos_ff, burst_pos_in;
   logic [CFG_W-1:0] chan_size_ff [CFG_COUNT];

   logic [7:0]  b;
   logic [15:0] cmd_full;
   logic [2:0]  cmd_ch;
   logic [7:0]  size_sel;
   logic [7:0]  lim;
   logic [15:0] cnt_next;

   function automatic logic [2:0] decode_channel(input logic [15:0] cmd);
      logic [2:0] ch;
      case (cmd)
         CMD_MOTION:   ch = CH_MOTION;
         CMD_ACTION:   ch = CH_ACTION;
         CMD_LIST:     ch = CH_LIST;
         CMD_DECISION: ch = CH_DECISION;
         CMD_CUSTOM:   ch = CH_CUSTOM;
         default:      ch = CH_UNKNOWN;
      endcase
      return ch;
   endfunction

   assign b        = req_payload.rx_byte;
   assign cmd_full = {b, command_word_ff[7:0]};
   assign cmd_ch   = decode_channel(cmd_full);
   assign size_sel = (active_channel_ff < CH_UNKNOWN) ? chan_size_ff[active_channel_ff] : '0;
   assign lim      = (frame_length_ff < {8'h00, size_sel}) ? frame_length_ff[7:0] : size_sel;
   assign cnt_next = byte_counter_ff + 16'd1;

   always_comb begin
      phase_in          = phase_ff;
      frame_length_in   = frame_length_ff;
      command_word_in   = command_word_ff;
      byte_counter_in   = byte_counter_ff;
      active_channel_in = active_channel_ff;
      alive_in          = alive_ff;
      burst_pos_in      = burst_pos_ff;
      result            = '0;
      result.payload.alive_mask = alive_ff;

      if (accept) begin
         if (burst_pos_ff < PosW'(BurstBytes)) begin
            burst_pos_in = burst_pos_ff + PosW'(1);
            case (phase_ff)
               PH_START: begin
                  phase_in = (b == START_BYTE) ? PH_LEN_LO : PH_HALT;
               end
               PH_LEN_LO: begin
                  frame_length_in = {8'h00, b};
                  phase_in        = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  frame_length_in = {b, frame_length_ff[7:0]};
                  phase_in        = PH_SEQ;
               end
               PH_SEQ:    phase_in = PH_HCRC;
               PH_HCRC:   phase_in = PH_CMD_LO;
               PH_CMD_LO: begin
                  command_word_in = {8'h00, b};
                  phase_in        = PH_CMD_HI;
               end
               PH_CMD_HI: begin
                  command_word_in   = cmd_full;
                  active_channel_in = cmd_ch;
                  byte_counter_in   = '0;
                  if (cmd_ch != CH_UNKNOWN) begin
                     alive_in                   = alive_ff | (5'd1 << cmd_ch);
                     result.valid               = 1'b1;
                     result.payload.kind        = KIND_EVENT;
                     result.payload.channel     = cmd_ch;
                     result.payload.alive_mask  = alive_ff | (5'd1 << cmd_ch);
                     result.payload.notify_code =
                        (cmd_ch == CH_CUSTOM)   ? NOTIFY_CUSTOM :
                        (cmd_ch == CH_DECISION) ? NOTIFY_DECISION : NOTIFY_NONE;
                  end
                  phase_in = (frame_length_ff == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
               end
               PH_PAYLOAD: begin
                  // Forward only the first min(size, length) bytes.
                  if (active_channel_ff < CH_UNKNOWN && byte_counter_ff < {8'h00, lim}) begin
                     result.valid             = 1'b1;
                     result.payload.kind      = KIND_DATA;
                     result.payload.channel   = active_channel_ff;
                     result.payload.offset    = byte_counter_ff[7:0];
                     result.payload.data_byte = b;
                     result.payload.last_byte = (cnt_next == {8'h00, lim});
                  end
                  byte_counter_in = cnt_next;
                  if (cnt_next == frame_length_ff) begin
                     phase_in = PH_CRC_LO;
                  end
               end
               PH_CRC_LO: phase_in = PH_CRC_HI;
               PH_CRC_HI: phase_in = PH_START;
               default:   phase_in = PH_HALT;
            endcase
         end
         // Burst end resyncs the parser whatever the phase.
         if (req_payload.burst_end) begin
            phase_in     = PH_START;
            burst_pos_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_START;
         frame_length_ff   <= '0;
         command_word_ff   <= '0;
         byte_counter_ff   <= '0;
         active_channel_ff <= CH_UNKNOWN;
         alive_ff          <= '0;
         burst_pos_ff      <= '0;
         for (int i = 0; i < CFG_COUNT; i++) begin
            chan_size_ff[i] <= CFG_RESET[i];
         end
      end else begin
         phase_ff          <= phase_in;
         frame_length_ff   <= frame_length_in;
         command_word_ff   <= command_word_in;
         byte_counter_ff   <= byte_counter_in;
         active_channel_ff <= active_channel_in;
         alive_ff          <= alive_in;
         burst_pos_ff      <= burst_pos_in;
         if (csr_we && csr_index < CSR_IDX_W'(CFG_COUNT)) begin
            chan_size_ff[csr_index] <= csr_wdata;
         end
      end
   end

endmodule

>>> rtl/cfd_outq.sv
// Output register with skid entry for the result channel.
// Depends on cfd_pkg; stall toward the parser comes from the skid entry only.
`timescale 1ns / 1ps

module cfd_outq import cfd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfd_result_type  result,
   output logic            full,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type main_ff, main_in;
   rsp_payload_type skid_ff, skid_in;
   logic            pop;

   assign pop         = main_valid_ff && !rsp_stall;
   assign full        = skid_valid_ff;
   assign rsp_valid   = main_valid_ff;
   assign rsp_payload = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff && !pop;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      // Advance the skid beat into the output register once it frees up.
      if (!main_valid_in && skid_valid_in) begin
         main_valid_in = 1'b1;
         main_in       = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (result.valid) begin
         if (!main_valid_in) begin
            main_valid_in = 1'b1;
            main_in       = result.payload;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = result.payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

>>> rtl/command_frame_deframer_router_top.sv
// A result is registered in the output register, or in its skid entry while that register is occupied.
// Accepts one byte per cycle while req_stall is low; the parse step is a single registered phase update.
// req_stall rises only when both the output register and its skid entry hold beats.
// Reset (synchronous, active high) returns the parser to expect-start, clears alive
// bits and the burst position, empties the output queue and restores channel sizes.
// Depends on cfd_pkg, cfd_parse, cfd_outq and the assertion macro header.
`timescale 1ns / 1ps
`include "command_frame_deframer_router_top_defines.svh"

module command_frame_deframer_router_top import cfd_pkg::*; #(
   parameter int BURST_BYTES = BURST_BYTES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   logic           accept;
   logic           full;
   cfd_result_type result;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   cfd_parse #(
      .BurstBytes(BURST_BYTES)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_payload(req_payload),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .result     (result)
   );

   cfd_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .full       (full),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   `CFD_ASSERT_IMP(a_skid_implies_main, req_stall, rsp_valid)
   `CFD_ASSERT_IMP(a_event_fields, rsp_valid && rsp_payload.kind == KIND_EVENT, rsp_payload.offset == 8'd0 && rsp_payload.data_byte == 8'd0 && !rsp_payload.last_byte)
   `CFD_ASSERT_IMP(a_data_fields, rsp_valid && rsp_payload.kind == KIND_DATA, rsp_payload.notify_code == NOTIFY_NONE && rsp_payload.channel < CH_UNKNOWN)
   `CFD_ASSERT_NEXT(a_no_result_when_idle, !accept && !req_stall, !req_stall)

endmodule

>>> test/command_frame_deframer_router_top_tb.sv
// Self-checking bench for command_frame_deframer_router_top: builds link bursts of
// framed commands, predicts the routed beats in step and checks every rsp beat.
// Depends on cfd_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module command_frame_deframer_router_top_tb;
   import cfd_pkg::*;

   localparam int BURST_LIMIT = BURST_BYTES_DEFAULT;
   localparam int IDLE_LIMIT  = 2000;
   localparam int PHASE_BYTES = 110;

   typedef enum logic [3:0] {
      WAIT_SYNC, LEN_LO, LEN_HI, SEQ_NUM, HDR_CRC, CMD_LO, CMD_HI,
      PAYLOAD, CRC_LO, CRC_HI, HALTED
   } parse_step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_payload_type      req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_payload_type      rsp_payload;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   command_frame_deframer_router_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Link bytes waiting for the driver, and routed beats the DUT still owes.
   req_payload_type link_bytes [$];
   rsp_payload_type routed_due [$];
   int              bytes_queued = 0;
   int              mismatches = 0;

   // Deframer shadow state.
   parse_step_type parse_at = WAIT_SYNC;
   logic [15:0] frame_len = '0;
   logic [15:0] cmd_word = '0;
   logic [15:0] pay_count = '0;
   logic [2:0]  cur_chan = CH_UNKNOWN;
   logic [4:0]  alive = '0;
   int          burst_count = 0;
   logic [CFG_W-1:0] chan_bytes [CFG_COUNT];
   logic [CFG_W-1:0] next_sizes [CFG_COUNT];

   initial begin
      for (int i = 0; i < CFG_COUNT; i++) chan_bytes[i] = CFG_RESET[i];
   end

   function automatic logic [2:0] chan_of(input logic [15:0] cmd);
      case (cmd)
         CMD_MOTION:   return CH_MOTION;
         CMD_ACTION:   return CH_ACTION;
         CMD_LIST:     return CH_LIST;
         CMD_DECISION: return CH_DECISION;
         CMD_CUSTOM:   return CH_CUSTOM;
         default:      return CH_UNKNOWN;
      endcase
   endfunction

   // Advance the shadow parser by one link byte; queue any routed beat it yields.
   function automatic void route_byte(input req_payload_type beat);
      rsp_payload_type r;
      logic [15:0]     lim;
      r = '0;
      if (burst_count < BURST_LIMIT) begin
         burst_count++;
         case (parse_at)
            WAIT_SYNC: parse_at = (beat.rx_byte == START_BYTE) ? LEN_LO : HALTED;
            LEN_LO: begin
               frame_len = {8'h00, beat.rx_byte};
               parse_at = LEN_HI;
            end
            LEN_HI: begin
               frame_len[15:8] = beat.rx_byte;
               parse_at = SEQ_NUM;
            end
            SEQ_NUM: parse_at = HDR_CRC;
            HDR_CRC: parse_at = CMD_LO;
            CMD_LO: begin
               cmd_word = {8'h00, beat.rx_byte};
               parse_at = CMD_HI;
            end
            CMD_HI: begin
               cmd_word[15:8] = beat.rx_byte;
               cur_chan = chan_of(cmd_word);
               pay_count = '0;
               if (cur_chan != CH_UNKNOWN) begin
                  alive = alive | (5'b00001 << cur_chan);
                  r.kind = KIND_EVENT;
                  r.channel = cur_chan;
                  r.notify_code = (cur_chan == CH_CUSTOM) ? NOTIFY_CUSTOM :
                                  (cur_chan == CH_DECISION) ? NOTIFY_DECISION : NOTIFY_NONE;
                  r.alive_mask = alive;
                  routed_due.push_back(r);
               end
               parse_at = (frame_len == 16'd0) ? CRC_LO : PAYLOAD;
            end
            PAYLOAD: begin
               if (cur_chan != CH_UNKNOWN) begin
                  lim = {8'h00, chan_bytes[cur_chan]};
                  if (frame_len < lim) lim = frame_len;
                  if (pay_count < lim) begin
                     r.kind = KIND_DATA;
                     r.channel = cur_chan;
                     r.offset = pay_count[7:0];
                     r.data_byte = beat.rx_byte;
                     r.last_byte = ((pay_count + 16'd1) == lim);
                     r.alive_mask = alive;
                     routed_due.push_back(r);
                  end
               end
               pay_count = pay_count + 16'd1;
               if (pay_count == frame_len) parse_at = CRC_LO;
            end
            CRC_LO: parse_at = CRC_HI;
            CRC_HI: parse_at = WAIT_SYNC;
            default: parse_at = HALTED;
         endcase
      end
      if (beat.burst_end) begin
         parse_at = WAIT_SYNC;
         burst_count = 0;
      end
   endfunction

   task automatic check_beat(input rsp_payload_type want, input rsp_payload_type got);
      if (got.kind !== want.kind) begin
         $error("kind: expected %0d, actual %0d", want.kind, got.kind);
         mismatches++;
      end
      if (got.channel !== want.channel) begin
         $error("channel: expected %0d, actual %0d", want.channel, got.channel);
         mismatches++;
      end
      if (got.offset !== want.offset) begin
         $error("offset: expected %0d, actual %0d", want.offset, got.offset);
         mismatches++;
      end
      if (got.data_byte !== want.data_byte) begin
         $error("data_byte: expected %0h, actual %0h", want.data_byte, got.data_byte);
         mismatches++;
      end
      if (got.notify_code !== want.notify_code) begin
         $error("notify_code: expected %0d, actual %0d", want.notify_code, got.notify_code);
         mismatches++;
      end
      if (got.last_byte !== want.last_byte) begin
         $error("last_byte: expected %0d, actual %0d", want.last_byte, got.last_byte);
         mismatches++;
      end
      if (got.alive_mask !== want.alive_mask) begin
         $error("alive_mask: expected %0h, actual %0h", want.alive_mask, got.alive_mask);
         mismatches++;
      end
   endtask

   // Sender: bursts of beats separated by random gaps.
   int gap_left = 0;
   int burst_left = 1;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) route_byte(req_payload);
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (link_bytes.size() == 0) begin
               req_valid <= 1'b0;
            end else begin
               req_payload <= link_bytes.pop_front();
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // Receiver: stall mode steps through four patterns as a free-running counter advances.
   int rx_cycle = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rx_cycle++;
         case ((rx_cycle / 64) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= (rx_cycle % 4 != 0);
            default: rsp_stall <= ($urandom_range(0, 99) < 70);
         endcase
         if (rsp_valid && !rsp_stall) begin
            if (routed_due.size() == 0) begin
               $error("unexpected rsp beat %h", rsp_payload);
               mismatches++;
            end else begin
               check_beat(routed_due.pop_front(), rsp_payload);
            end
         end
      end
   end

   // Abort if neither channel moves a beat for too long.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic push_beat(input logic [7:0] b, input bit ends);
      req_payload_type p;
      p.rx_byte = b;
      p.burst_end = ends;
      link_bytes.push_back(p);
      bytes_queued++;
   endtask

   // Queue one frame; 0 < cut < size truncates it to cut bytes and ends the burst.
   task automatic push_frame(input logic [15:0] cmd, input logic [15:0] len, input int cut,
                             input bit close);
      logic [7:0] fb [$];
      int         n;
      int         body;
      fb.push_back(START_BYTE);
      fb.push_back(len[7:0]);
      fb.push_back(len[15:8]);
      fb.push_back(8'($urandom_range(0, 255)));
      fb.push_back(8'($urandom_range(0, 255)));
      fb.push_back(cmd[7:0]);
      fb.push_back(cmd[15:8]);
      body = (len > 300) ? 300 : int'(len);
      repeat (body) fb.push_back(8'($urandom_range(0, 255)));
      // long frames never finish inside one burst window
      if (len <= 300) begin
         fb.push_back(8'($urandom_range(0, 255)));
         fb.push_back(8'($urandom_range(0, 255)));
      end else begin
         close = 1'b1;
      end
      n = fb.size();
      if (cut > 0 && cut < n) begin
         n = cut;
         close = 1'b1;
      end
      for (int i = 0; i < n; i++) push_beat(fb[i], close && (i == n - 1));
   endtask

   function automatic logic [15:0] pick_command();
      int r;
      logic [15:0] c;
      r = $urandom_range(0, 4);
      case (r)
         0: c = CMD_MOTION;
         1: c = CMD_ACTION;
         2: c = CMD_LIST;
         3: c = CMD_DECISION;
         default: c = CMD_CUSTOM;
      endcase
      r = $urandom_range(0, 99);
      if (r >= 90) c = 16'($urandom_range(0, 65535));
      else if (r >= 80) c = c ^ (16'd1 << $urandom_range(0, 15));
      return c;
   endfunction

   function automatic logic [15:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 16'd0;
      if (r < 85) return 16'($urandom_range(1, 12));
      if (r < 96) return 16'($urandom_range(13, 40));
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic random_burst();
      int          style;
      int          nframes;
      int          n;
      int          cut;
      bit          tail_bad;
      logic [15:0] len;
      logic [7:0]  b;
      style = $urandom_range(0, 99);
      if (style < 8) begin
         n = $urandom_range(1, 20);
         for (int i = 0; i < n; i++) push_beat(8'($urandom_range(0, 255)), i == n - 1);
         return;
      end
      // a few bursts run past the burst window
      nframes = (style < 13) ? $urandom_range(8, 14) : $urandom_range(1, 4);
      tail_bad = (style >= 13 && style < 22);
      for (int f = 0; f < nframes; f++) begin
         len = pick_length();
         cut = 0;
         if (f == nframes - 1 && !tail_bad && $urandom_range(0, 9) == 0)
            cut = $urandom_range(1, 9 + ((len > 300) ? 300 : int'(len)));
         push_frame(pick_command(), len, cut, (f == nframes - 1) && !tail_bad);
      end
      if (tail_bad) begin
         b = 8'($urandom_range(0, 254));
         if (b >= START_BYTE) b = b + 8'd1;
         n = $urandom_range(0, 5);
         push_beat(b, n == 0);
         for (int i = 0; i < n; i++) push_beat(8'($urandom_range(0, 255)), i == n - 1);
      end
   endtask

   task automatic random_bytes(input int target);
      int start;
      start = bytes_queued;
      while (bytes_queued - start < target) random_burst();
   endtask

   // Hold until every queued byte is taken and every routed beat has arrived.
   task automatic settle();
      do @(negedge clock);
      while (link_bytes.size() != 0 || req_valid || routed_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_sizes(input bit stray);
      for (int i = 0; i < CFG_COUNT; i++) begin
         @(posedge clock);
         csr_we <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= next_sizes[i];
         chan_bytes[i] = next_sizes[i];
      end
      // indexes past the last register must be dropped
      if (stray) begin
         for (int i = CFG_COUNT; i < (1 << CSR_IDX_W); i++) begin
            @(posedge clock);
            csr_we <= 1'b1;
            csr_index <= CSR_IDX_W'(i);
            csr_wdata <= CFG_W'($urandom_range(0, 255));
         end
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset sizes
      push_frame(CMD_MOTION, 16'd3, 0, 1'b0);
      push_frame(CMD_CUSTOM, 16'd2, 0, 1'b1);
      push_frame(CMD_DECISION, 16'd20, 0, 1'b1);
      push_frame(16'h1234, 16'd2, 0, 1'b0);
      push_frame(CMD_LIST, 16'd1, 0, 1'b1);
      push_frame(CMD_ACTION, 16'd0, 0, 1'b1);
      push_beat(8'h5A, 1'b0);
      push_beat(START_BYTE, 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(8'hFF, 1'b1);
      push_frame(CMD_MOTION, 16'd10, 9, 1'b1);
      push_frame(CMD_CUSTOM, 16'hFFFF, 0, 1'b1);
      random_bytes(PHASE_BYTES);

      for (int ph = 1; ph <= 4; ph++) begin
         settle();
         for (int i = 0; i < CFG_COUNT; i++) begin
            case (ph)
               1: next_sizes[i] = 8'hFF;
               2: next_sizes[i] = 8'h00;
               3: next_sizes[i] = CFG_W'($urandom_range(0, 255));
               default: next_sizes[i] = CFG_W'(i + 1);
            endcase
         end
         program_sizes(ph == 1);
         random_bytes(PHASE_BYTES);
      end

      settle();
      repeat (6) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> command_frame_deframer_router_top.f
+incdir+rtl
rtl/cfd_pkg.sv
rtl/cfd_parse.sv
rtl/cfd_outq.sv
rtl/command_frame_deframer_router_top.sv
test/command_frame_deframer_router_top_tb.sv
